// File: rtl/ivm_pkg.sv
// ----------------------------------------------------------------------------
// ivm_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ivm_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 8;

    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    localparam logic REG_DEFAULT = 1'b0;

    typedef struct packed {
        logic load;        // capture operands, clear walk index
        logic inc;         // advance walk index
        logic wr_entry;    // copy current entry to the other bank
        logic wr_b;        // write (begin_key, new_value)
        logic wr_e;        // write (end_key, after)
        logic set_before;  // before <= current entry value
        logic init_after;  // after <= before
        logic set_after;   // after <= current entry value
        logic emit;        // drive result
        logic commit;      // swap banks if the new table fits
    } t_cmd;

    typedef struct packed {
        logic idx_lt_cnt;
        logic key_lt_b;
        logic key_le_b;
        logic key_le_e;
        logic before_ne_v;
        logic after_ne_v;
        logic is_lookup;
        logic range_ok;
    } t_sts;

endpackage

// File: rtl/ivm_ctrl.sv
// ----------------------------------------------------------------------------
// ivm_ctrl
// sequencer for lookup walk and assign merge into the spare bank
// ----------------------------------------------------------------------------
module ivm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ivm_pkg::t_sts i_sts,
    output ivm_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DISP = 9'b000000010,
        S_LOOK = 9'b000000100,
        S_LOW  = 9'b000001000,
        S_INSB = 9'b000010000,
        S_MID  = 9'b000100000,
        S_INSE = 9'b001000000,
        S_HIGH = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_commit, n_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_commit <= n_commit;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_commit = r_commit;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_commit = 1'b0;
                if (i_sts.is_lookup) begin
                    n_state = S_LOOK;
                end else if (i_sts.range_ok) begin
                    n_state  = S_LOW;
                    n_commit = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOOK: begin
                if (i_sts.idx_lt_cnt && i_sts.key_le_b) begin
                    o_cmd.set_before = 1'b1;
                    o_cmd.inc        = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LOW: begin
                if (i_sts.idx_lt_cnt && i_sts.key_lt_b) begin
                    o_cmd.wr_entry   = 1'b1;
                    o_cmd.set_before = 1'b1;
                    o_cmd.inc        = 1'b1;
                end else begin
                    n_state = S_INSB;
                end
            end
            S_INSB: begin
                o_cmd.wr_b       = i_sts.before_ne_v;
                o_cmd.init_after = 1'b1;
                n_state          = S_MID;
            end
            S_MID: begin
                // breakpoints inside the range are dropped
                if (i_sts.idx_lt_cnt && i_sts.key_le_e) begin
                    o_cmd.set_after = 1'b1;
                    o_cmd.inc       = 1'b1;
                end else begin
                    n_state = S_INSE;
                end
            end
            S_INSE: begin
                o_cmd.wr_e = i_sts.after_ne_v;
                n_state    = S_HIGH;
            end
            S_HIGH: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.wr_entry = 1'b1;
                    o_cmd.inc      = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit   = 1'b1;
                o_cmd.commit = r_commit;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: rtl/ivm_dp.sv
// ----------------------------------------------------------------------------
// ivm_dp
// two-bank breakpoint memory, walk index, merge registers and result
// ----------------------------------------------------------------------------
module ivm_dp #(
    parameter int CAPACITY   = ivm_pkg::CAPACITY,
    parameter int KEY_BITS   = ivm_pkg::KEY_BITS,
    parameter int VALUE_BITS = ivm_pkg::VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ivm_pkg::t_cmd         i_cmd,
    output ivm_pkg::t_sts         o_sts,
    input  logic                  i_action,
    input  logic [KEY_BITS-1:0]   i_begin_key,
    input  logic [KEY_BITS-1:0]   i_end_key,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic                  i_cfg_wr,
    input  logic [7:0]            i_cfg_data,
    output logic [VALUE_BITS-1:0] o_default,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_status,
    output logic [6:0]            o_entries_used
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int NW = $clog2(CAPACITY + 3);
    localparam int DW = KEY_BITS + VALUE_BITS;
    localparam int MD = 2 * (2 ** AW);

    logic [DW-1:0] mem [0:MD-1];

    logic [DW-1:0]         r_rdata;
    logic [IW-1:0]         r_idx, n_idx;
    logic [NW-1:0]         r_nwr;
    logic [IW-1:0]         r_count;
    logic                  r_bank;
    logic [VALUE_BITS-1:0] r_default;
    logic                  r_lookup;
    logic [KEY_BITS-1:0]   r_b, r_e;
    logic [VALUE_BITS-1:0] r_v, r_before, r_after;

    logic [KEY_BITS-1:0]   cur_key;
    logic [VALUE_BITS-1:0] cur_val;
    logic                  wr_any;
    logic [DW-1:0]         wr_data;
    logic                  fits;

    assign cur_key = r_rdata[DW-1:VALUE_BITS];
    assign cur_val = r_rdata[VALUE_BITS-1:0];

    always_comb begin
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.inc) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    assign wr_any = i_cmd.wr_entry | i_cmd.wr_b | i_cmd.wr_e;

    always_comb begin
        if (i_cmd.wr_b) begin
            wr_data = {r_b, r_v};
        end else if (i_cmd.wr_e) begin
            wr_data = {r_e, r_after};
        end else begin
            wr_data = r_rdata;
        end
    end

    // read address looks ahead so data matches the walk index
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[{r_bank, n_idx[AW-1:0]}];
        if (wr_any && (r_nwr < NW'(CAPACITY))) begin
            mem[{~r_bank, r_nwr[AW-1:0]}] <= wr_data;
        end
    end

    assign fits = (r_nwr <= NW'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_nwr     <= '0;
            r_count   <= '0;
            r_bank    <= 1'b0;
            r_default <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            o_valid <= i_cmd.emit;
            if (i_cfg_wr) begin
                r_default <= VALUE_BITS'(i_cfg_data);
            end
            if (i_cmd.load) begin
                r_nwr <= '0;
            end else if (wr_any) begin
                r_nwr <= r_nwr + 1'b1;
            end
            if (i_cmd.commit && fits) begin
                r_bank  <= ~r_bank;
                r_count <= IW'(r_nwr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lookup <= (i_action == ivm_pkg::ACT_LOOKUP);
            r_b      <= i_begin_key;
            r_e      <= i_end_key;
            r_v      <= i_new_value;
            r_before <= r_default;
        end else if (i_cmd.set_before) begin
            r_before <= cur_val;
        end
        if (i_cmd.init_after) begin
            r_after <= r_before;
        end else if (i_cmd.set_after) begin
            r_after <= cur_val;
        end
        if (i_cmd.emit) begin
            o_read_value <= r_lookup ? r_before : '0;
            o_status     <= (i_cmd.commit && !fits) ? ivm_pkg::ST_FULL : ivm_pkg::ST_DONE;
            o_entries_used <= (i_cmd.commit && fits) ? 7'(r_nwr) : 7'(r_count);
        end
    end

    assign o_sts.idx_lt_cnt  = (r_idx < r_count);
    assign o_sts.key_lt_b    = (cur_key < r_b);
    assign o_sts.key_le_b    = (cur_key <= r_b);
    assign o_sts.key_le_e    = (cur_key <= r_e);
    assign o_sts.before_ne_v = (r_before != r_v);
    assign o_sts.after_ne_v  = (r_after != r_v);
    assign o_sts.is_lookup   = r_lookup;
    assign o_sts.range_ok    = (r_b < r_e);

    assign o_default = r_default;

endmodule

// File: rtl/interval_value_map.sv
// ----------------------------------------------------------------------------
// interval_value_map
// canonical key-range to value map with assign and lookup commands
// ----------------------------------------------------------------------------
// lookup walks the breakpoints at or below the key before the result strobe;
// assign walks all the breakpoints held; both walks read one entry per cycle
// over the memory port
// throughput: one item at a time, next start taken once busy drops
// reset: table emptied (count zero), default value zero; results cannot stall
// ----------------------------------------------------------------------------
module interval_value_map #(
    parameter int CAPACITY   = ivm_pkg::CAPACITY,
    parameter int KEY_BITS   = ivm_pkg::KEY_BITS,
    parameter int VALUE_BITS = ivm_pkg::VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_action,
    input  logic [KEY_BITS-1:0]   i_begin_key,
    input  logic [KEY_BITS-1:0]   i_end_key,
    input  logic [VALUE_BITS-1:0] i_new_value,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_status,
    output logic [6:0]            o_entries_used,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [0:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ivm_pkg::t_cmd         cmd;
    ivm_pkg::t_sts         sts;
    logic                  cfg_wr;
    logic [VALUE_BITS-1:0] dflt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ivm_pkg::REG_DEFAULT);
    assign prdata = (paddr == ivm_pkg::REG_DEFAULT) ? 32'(dflt) : '0;

    ivm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ivm_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_begin_key    (i_begin_key),
        .i_end_key      (i_end_key),
        .i_new_value    (i_new_value),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_data     (pwdata[7:0]),
        .o_default      (dflt),
        .o_valid        (o_valid),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_read_value == '0)) else $error("full with read value");

endmodule
